// ----- hdl/cram_pkg.sv -----
// Shared widths, selection tables and queue word type for the 3x3 Cramer solver.
`timescale 1ns / 1ps
`default_nettype none
package cram_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // 2x2 products and minors
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int MINOR_W = 2 * DATA_WIDTH + 1;
  // 3x3 determinant: six triple products of magnitude <= 2^(3*DATA_WIDTH-3)
  localparam int MAG_W   = 3 * DATA_WIDTH;
  localparam int DET_W   = MAG_W + 1;
  // divider working width: shifted numerator and shifted divisor both fit
  localparam int REM_W   = MAG_W + DATA_WIDTH + FRAC_BITS;

  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);

  // Operand indices: a11..a33 = 0..8, b1..b3 = 9..11.
  // 2x2 minor k = prod[2k] - prod[2k+1]; minors of columns (2,3), negated minors
  // of columns (1,3), minors of columns (1,2).
  localparam logic [3:0] MUL_A [18] = '{4, 5, 1, 2, 1, 2, 5, 3, 2, 0, 2, 0, 3, 4, 0, 1, 0, 1};
  localparam logic [3:0] MUL_B [18] = '{8, 7, 8, 7, 5, 4, 6, 8, 6, 8, 3, 5, 7, 6, 7, 6, 4, 3};

  // Term j = minor[MIN_SEL[j]] * operand[FAC_SEL[j]]; det k = t[3k] - t[3k+1] + t[3k+2]
  localparam logic [3:0] MIN_SEL [12] = '{0, 1, 2, 0, 1, 2, 3, 4, 5, 6, 7, 8};
  localparam logic [3:0] FAC_SEL [12] = '{0, 3, 6, 9, 10, 11, 9, 10, 11, 9, 10, 11};

  // Word handed from the front end to the divider back end
  typedef struct packed {
    logic [MAG_W-1:0]      dmag;
    logic [2:0][MAG_W-1:0] nmag;
    logic [2:0]            neg;
    logic                  solved;
  } cram_job_t;

endpackage
`default_nettype wire

// ----- hdl/cram_front.sv -----
// Front end: takes a system, forms the four determinants and classifies them.
`timescale 1ns / 1ps
`default_nettype none
module cram_front import cram_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] opnd [12],
  input  logic                         q_full,
  output logic                         push,
  output cram_job_t                    job
);

  logic [5:0] fv;
  logic       fen;

  logic signed [DATA_WIDTH-1:0] v1 [12];
  logic signed [DATA_WIDTH-1:0] v2 [12];
  logic signed [PROD_W-1:0]     p1 [18];
  logic signed [MINOR_W-1:0]    m2 [9];
  logic signed [DATA_WIDTH:0]   hi_c [12];
  logic signed [DATA_WIDTH:0]   lo_c [12];
  logic signed [MINOR_W-1:0]    hp3 [12];
  logic signed [MINOR_W-1:0]    lp3 [12];
  logic signed [DET_W-1:0]      t4 [12];
  logic signed [DET_W-1:0]      d5 [4];
  logic signed [DET_W-1:0]      abs_c [4];
  cram_job_t                    job_c;

  // whole front moves together; it holds only when the last stage cannot drain
  assign fen      = !(fv[5] && q_full);
  assign in_ready = fen;
  assign push     = fen && fv[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (fen) begin
      fv <= {fv[4:0], in_valid};
    end
  end

  // split each minor into a signed high half and an unsigned low half
  always_comb begin
    for (int j = 0; j < 12; j++) begin
      hi_c[j] = $signed(m2[MIN_SEL[j]][MINOR_W-1:DATA_WIDTH]);
      lo_c[j] = $signed({1'b0, m2[MIN_SEL[j]][DATA_WIDTH-1:0]});
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      abs_c[k] = d5[k][DET_W-1] ? -d5[k] : d5[k];
    end
    job_c.dmag   = abs_c[0][MAG_W-1:0];
    job_c.solved = |d5[0];
    for (int k = 0; k < 3; k++) begin
      job_c.nmag[k] = abs_c[k+1][MAG_W-1:0];
      job_c.neg[k]  = d5[k+1][DET_W-1] ^ d5[0][DET_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      for (int i = 0; i < 12; i++) begin
        v1[i] <= opnd[i];
        v2[i] <= v1[i];
      end
      for (int i = 0; i < 18; i++) begin
        p1[i] <= opnd[MUL_A[i]] * opnd[MUL_B[i]];
      end
      for (int k = 0; k < 9; k++) begin
        m2[k] <= MINOR_W'(p1[2*k]) - MINOR_W'(p1[2*k+1]);
      end
      for (int j = 0; j < 12; j++) begin
        hp3[j] <= hi_c[j] * v2[FAC_SEL[j]];
        lp3[j] <= lo_c[j] * v2[FAC_SEL[j]];
        t4[j]  <= (DET_W'(hp3[j]) <<< DATA_WIDTH) + DET_W'(lp3[j]);
      end
      for (int k = 0; k < 4; k++) begin
        d5[k] <= t4[3*k] - t4[3*k+1] + t4[3*k+2];
      end
      job <= job_c;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cram_queue.sv -----
// Short word queue between the determinant front end and the divider back end.
`timescale 1ns / 1ps
`default_nettype none
module cram_queue import cram_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cram_job_t job,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output cram_job_t head
);

  cram_job_t        mem [QDEPTH];
  logic [QAW-1:0]   wp;
  logic [QAW-1:0]   rp;
  logic [QAW:0]     cnt;

  assign full       = (cnt == (QAW+1)'(QDEPTH));
  assign head_valid = (cnt != '0);
  assign head       = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= job;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cram_div.sv -----
// One divider lane: restoring division, one quotient bit per stage, then clamp and sign.
`timescale 1ns / 1ps
`default_nettype none
module cram_div import cram_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [MAG_W-1:0]      nmag,
  input  logic [MAG_W-1:0]      dmag,
  input  logic                  neg_in,
  output logic [DATA_WIDTH-1:0] x,
  output logic                  sat
);

  logic [REM_W-1:0]      r [DATA_WIDTH+1];
  logic [MAG_W-1:0]      d [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] q [DATA_WIDTH+1];
  logic [DATA_WIDTH:0]   big;
  logic [DATA_WIDTH:0]   neg;
  logic [REM_W-1:0]      trial [DATA_WIDTH+1];
  logic [REM_W-1:0]      num_c;
  logic [DATA_WIDTH-1:0] lim;
  logic [DATA_WIDTH-1:0] mag;

  assign num_c = REM_W'(nmag) << FRAC_BITS;

  // stage i tries quotient bit DATA_WIDTH-i
  always_comb begin
    trial[0] = '0;
    for (int i = 1; i <= DATA_WIDTH; i++) begin
      trial[i] = REM_W'(d[i-1]) << (DATA_WIDTH - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quotient needs more than DATA_WIDTH bits -> clamp later
      r[0]   <= num_c;
      d[0]   <= dmag;
      q[0]   <= '0;
      big[0] <= (num_c >= (REM_W'(dmag) << DATA_WIDTH));
      neg[0] <= neg_in;
      for (int i = 1; i <= DATA_WIDTH; i++) begin
        d[i]   <= d[i-1];
        big[i] <= big[i-1];
        neg[i] <= neg[i-1];
        if (r[i-1] >= trial[i]) begin
          r[i] <= r[i-1] - trial[i];
          q[i] <= q[i-1] | (DATA_WIDTH'(1) << (DATA_WIDTH - i));
        end else begin
          r[i] <= r[i-1];
          q[i] <= q[i-1];
        end
      end
    end
  end

  always_comb begin
    lim = neg[DATA_WIDTH] ? (DATA_WIDTH'(1) << (DATA_WIDTH - 1))
                          : ((DATA_WIDTH'(1) << (DATA_WIDTH - 1)) - 1'b1);
    sat = big[DATA_WIDTH] || (q[DATA_WIDTH] > lim);
    mag = sat ? lim : q[DATA_WIDTH];
    x   = neg[DATA_WIDTH] ? (DATA_WIDTH'(0) - mag) : mag;
  end

endmodule
`default_nettype wire

// ----- hdl/cram_back.sv -----
// Back end: three divider lanes, singular-matrix override and the output register.
`timescale 1ns / 1ps
`default_nettype none
module cram_back import cram_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  cram_job_t                    head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] x1,
  output logic signed [DATA_WIDTH-1:0] x2,
  output logic signed [DATA_WIDTH-1:0] x3,
  output logic                         solved,
  output logic                         saturated
);

  logic                  en;
  logic [DATA_WIDTH:0]   bv;
  logic [DATA_WIDTH:0]   sv;
  logic [DATA_WIDTH-1:0] xl [3];
  logic [2:0]            satl;

  assign en  = !out_valid || out_ready;
  assign pop = en && head_valid;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    cram_div u_div (
      .clk    (clk),
      .en     (en),
      .nmag   (head.nmag[k]),
      .dmag   (head.dmag),
      .neg_in (head.neg[k]),
      .x      (xl[k]),
      .sat    (satl[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      bv        <= {bv[DATA_WIDTH-1:0], head_valid};
      out_valid <= bv[DATA_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv        <= {sv[DATA_WIDTH-1:0], head.solved};
      x1        <= sv[DATA_WIDTH] ? $signed(xl[0]) : '0;
      x2        <= sv[DATA_WIDTH] ? $signed(xl[1]) : '0;
      x3        <= sv[DATA_WIDTH] ? $signed(xl[2]) : '0;
      solved    <= sv[DATA_WIDTH];
      saturated <= sv[DATA_WIDTH] && (|satl);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cramer_3x3_solver_unit.sv -----
// Top level of the 3x3 Cramer's-rule solver: front end, word queue, divider back end.
// Pipeline: 6 determinant stages, the word queue, 33 divider stages, 1 output register.
// Throughput: one system per cycle while out_ready is high and the queue has room;
//   every stage is a register step of the pipelines.
// Reset: synchronous rst clears valid flags and queue pointers; data regs are not reset.
`timescale 1ns / 1ps
`default_nettype none
module cramer_3x3_solver_unit import cram_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  // input word: coefficients and constant terms, signed Q16.16
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] a11,
  input  logic signed [DATA_WIDTH-1:0] a12,
  input  logic signed [DATA_WIDTH-1:0] a13,
  input  logic signed [DATA_WIDTH-1:0] a21,
  input  logic signed [DATA_WIDTH-1:0] a22,
  input  logic signed [DATA_WIDTH-1:0] a23,
  input  logic signed [DATA_WIDTH-1:0] a31,
  input  logic signed [DATA_WIDTH-1:0] a32,
  input  logic signed [DATA_WIDTH-1:0] a33,
  input  logic signed [DATA_WIDTH-1:0] b1,
  input  logic signed [DATA_WIDTH-1:0] b2,
  input  logic signed [DATA_WIDTH-1:0] b3,
  // output word: unknowns and status
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] x1,
  output logic signed [DATA_WIDTH-1:0] x2,
  output logic signed [DATA_WIDTH-1:0] x3,
  output logic                         solved,
  output logic                         saturated
);

  logic signed [DATA_WIDTH-1:0] opnd [12];
  logic                         push;
  logic                         q_full;
  logic                         pop;
  logic                         head_valid;
  cram_job_t                    job;
  cram_job_t                    head;

  // operand order matches the selection tables in the package
  assign opnd = '{a11, a12, a13, a21, a22, a23, a31, a32, a33, b1, b2, b3};

  // Front: 18 2x2 products, 9 minors, 12 minor*operand terms (split in two
  // 33x32 halves), 4 determinants, then sign/magnitude split. Holds as a whole
  // only when its last stage is full and the queue has no room.
  cram_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opnd     (opnd),
    .q_full   (q_full),
    .push     (push),
    .job      (job)
  );

  // Queue decouples front stalls from output back-pressure.
  cram_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .job        (job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: overflow check plus one quotient bit per stage in each of three
  // lanes; a zero determinant forces zero unknowns with both flags low.
  cram_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .x1         (x1),
    .x2         (x2),
    .x3         (x3),
    .solved     (solved),
    .saturated  (saturated)
  );

endmodule
`default_nettype wire
